// ===== rtl/core/mf3_pkg.sv =====
package mf3_pkg;

  // Pixel format: three 8-bit channels, index 0 red, 1 green, 2 blue
  localparam int CHAN_W   = 8;
  localparam int NUM_CHAN = 3;

  typedef logic [CHAN_W-1:0]                 chan_t;
  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0]   rgb_t;

  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  // Result beat as held in the output buffer
  typedef struct packed {
    logic last;
    rgb_t px;
  } res_t;

  // 3x3 window geometry
  localparam int WIN_DIM  = 3;
  localparam int WIN_TAPS = 9;

  // Configuration registers
  localparam int IMG_W_BITS  = 11;
  localparam int IMG_H_BITS  = 16;
  localparam int IMG_W_RESET = 640;
  localparam int IMG_H_RESET = 480;
  localparam int MIN_DIM     = 3;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  typedef enum logic [ADDR_W-3:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  // Output buffer
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  function automatic chan_t min2(input chan_t a, input chan_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic chan_t max2(input chan_t a, input chan_t b);
    return (a > b) ? a : b;
  endfunction

  // Median of three values
  function automatic chan_t med3(input chan_t a, input chan_t b, input chan_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

endpackage

// ===== rtl/core/mf3_if.sv =====
// Input pixel channel
interface mf3_pix_if import mf3_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t in_red;
  chan_t in_green;
  chan_t in_blue;
  logic  frame_start;

  modport source (output valid, output in_red, output in_green, output in_blue,
                  output frame_start, input ready);
  modport sink   (input valid, input in_red, input in_green, input in_blue,
                  input frame_start, output ready);
endinterface

// Median result channel
interface mf3_res_if import mf3_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t med_red;
  chan_t med_green;
  chan_t med_blue;
  logic  frame_last;

  modport source (output valid, output med_red, output med_green, output med_blue,
                  output frame_last, input ready);
  modport sink   (input valid, input med_red, input med_green, input med_blue,
                  input frame_last, output ready);
endinterface

// ===== rtl/core/median_filter_3x3_rgb_core.sv =====
// Path to result.valid: line store read, window shift, median pipeline, then the output buffer.
// Throughput: one pixel per clock; each line store does one read and one write per cycle.
// Input stalls only when the 8-entry output buffer credit runs out under output back-pressure.
// Reset (rst, synchronous) clears counters, window, pipeline valids, buffer and registers
// (width 640, height 480); the line stores are not cleared and need no clearing pass.
module median_filter_3x3_rgb_core import mf3_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic              clk,
  input  logic              rst,
  mf3_pix_if.sink           pixel,
  mf3_res_if.source         result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int COLW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WCMP = (COLW + 1 > IMG_W_BITS) ? COLW + 1 : IMG_W_BITS;

  // ---------------- configuration registers ----------------
  logic [IMG_W_BITS-1:0] image_width;
  logic [IMG_H_BITS-1:0] image_height;
  reg_idx_t              reg_sel;
  logic                  cfg_we;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_we  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMG_W_BITS'(IMG_W_RESET);
      image_height <= IMG_H_BITS'(IMG_H_RESET);
    end else if (cfg_we) begin
      unique case (reg_sel)
        REG_IMAGE_WIDTH:  image_width  <= pwdata[IMG_W_BITS-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[IMG_H_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_IMAGE_WIDTH:  prdata = DATA_W'(image_width);
      REG_IMAGE_HEIGHT: prdata = DATA_W'(image_height);
    endcase
  end

  // Clamped frame geometry
  logic [WCMP-1:0]       w_raw, w_eff;
  logic [IMG_H_BITS-1:0] h_eff;

  always_comb begin
    w_raw = WCMP'(image_width);
    if (w_raw < WCMP'(MIN_DIM))        w_eff = WCMP'(MIN_DIM);
    else if (w_raw > WCMP'(MAX_WIDTH)) w_eff = WCMP'(MAX_WIDTH);
    else                               w_eff = w_raw;
    h_eff = (image_height < IMG_H_BITS'(MIN_DIM)) ? IMG_H_BITS'(MIN_DIM) : image_height;
  end

  // ---------------- input side: position counters ----------------
  logic                  accept;
  logic [OUT_CNT_W-1:0]  credits;
  logic [COLW-1:0]       col_cnt, col_cur, col_cnt_next;
  logic [IMG_H_BITS-1:0] row_cnt, row_cur, row_cnt_next;
  logic [WCMP-1:0]       col_inc;
  logic [IMG_H_BITS:0]   row_inc;
  logic                  col_wrap, produce, is_last;
  rgb_t                  in_px;

  assign pixel.ready = (credits < OUT_CNT_W'(OUT_DEPTH));
  assign accept      = pixel.valid & pixel.ready;

  always_comb begin
    in_px[CH_RED]   = pixel.in_red;
    in_px[CH_GREEN] = pixel.in_green;
    in_px[CH_BLUE]  = pixel.in_blue;
    col_cur  = pixel.frame_start ? '0 : col_cnt;
    row_cur  = pixel.frame_start ? '0 : row_cnt;
    col_inc  = WCMP'(col_cur) + WCMP'(1);
    row_inc  = {1'b0, row_cur} + (IMG_H_BITS+1)'(1);
    col_wrap = (col_inc >= w_eff);
    produce  = (row_cur >= IMG_H_BITS'(WIN_DIM - 1)) && (col_cur >= COLW'(WIN_DIM - 1));
    is_last  = (row_cur == h_eff - IMG_H_BITS'(1)) && (WCMP'(col_cur) == w_eff - WCMP'(1));
    if (col_wrap) begin
      col_cnt_next = '0;
      row_cnt_next = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[IMG_H_BITS-1:0];
    end else begin
      col_cnt_next = col_inc[COLW-1:0];
      row_cnt_next = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      col_cnt <= col_cnt_next;
      row_cnt <= row_cnt_next;
    end
  end

  // ---------------- line stores ----------------
  rgb_t line_a [MAX_WIDTH];
  rgb_t line_b [MAX_WIDTH];
  rgb_t rd_a, rd_b;

  // Stage 1 beat and the beat written in the previous cycle (for forwarding)
  logic            s1_valid, s1_res, s1_last;
  logic [COLW-1:0] s1_col;
  rgb_t            s1_px;
  logic            fwd_valid;
  logic [COLW-1:0] fwd_col;
  rgb_t            fwd_px, fwd_above;
  logic            fwd_hit;
  rgb_t            above, above2;

  // Read issued in the accept cycle, data back in stage 1
  always_ff @(posedge clk) begin
    rd_a <= line_a[col_cur];
    rd_b <= line_b[col_cur];
  end

  // Same column back to back: the write lands after the read, so forward it
  assign fwd_hit = fwd_valid && (fwd_col == s1_col);
  assign above   = fwd_hit ? fwd_px    : rd_a;
  assign above2  = fwd_hit ? fwd_above : rd_b;

  // Write back: new pixel to store A, old row moves to store B
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      line_a[s1_col] <= s1_px;
      line_b[s1_col] <= above;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      s1_valid  <= accept;
      fwd_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_col    <= col_cur;
    s1_px     <= in_px;
    s1_res    <= produce;
    s1_last   <= is_last;
    fwd_col   <= s1_col;
    fwd_px    <= s1_px;
    fwd_above <= above;
  end

  // ---------------- 3x3 window ----------------
  rgb_t win [WIN_TAPS];
  rgb_t new_col [WIN_DIM];
  logic s2_res, s2_last;

  assign new_col[0] = above2;
  assign new_col[1] = above;
  assign new_col[2] = s1_px;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WIN_TAPS; i++) win[i] <= '0;
      s2_res <= 1'b0;
    end else begin
      s2_res <= s1_valid & s1_res;
      if (s1_valid) begin
        for (int r = 0; r < WIN_DIM; r++) begin
          win[r*WIN_DIM]   <= win[r*WIN_DIM+1];
          win[r*WIN_DIM+1] <= win[r*WIN_DIM+2];
          win[r*WIN_DIM+2] <= new_col[r];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_last <= s1_last;
  end

  // ---------------- median pipeline ----------------
  logic med_valid, med_last;
  rgb_t med_px;

  mf3_median u_median (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_res),
    .in_last   (s2_last),
    .taps      (win),
    .out_valid (med_valid),
    .out_last  (med_last),
    .med       (med_px)
  );

  // ---------------- output buffer ----------------
  res_t                 fifo [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [OUT_CNT_W-1:0] fifo_cnt;
  logic                 pop;
  res_t                 head;

  assign head               = fifo[rd_ptr];
  assign result.valid       = (fifo_cnt != '0);
  assign result.med_red     = head.px[CH_RED];
  assign result.med_green   = head.px[CH_GREEN];
  assign result.med_blue    = head.px[CH_BLUE];
  assign result.frame_last  = head.last;
  assign pop                = result.valid & result.ready;

  always_ff @(posedge clk) begin
    if (med_valid) fifo[wr_ptr] <= '{last: med_last, px: med_px};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
    end else begin
      if (med_valid) wr_ptr <= wr_ptr + OUT_PTR_W'(1);
      if (pop)       rd_ptr <= rd_ptr + OUT_PTR_W'(1);
      fifo_cnt <= fifo_cnt + OUT_CNT_W'(med_valid) - OUT_CNT_W'(pop);
    end
  end

  // Credits: results promised (in flight or buffered), so the buffer never overflows
  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
    end else begin
      credits <= credits + OUT_CNT_W'(accept & produce) - OUT_CNT_W'(pop);
    end
  end

`ifndef SYNTH
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credits <= OUT_CNT_W'(OUT_DEPTH))
    else $error("credit count above buffer depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    med_valid |-> (fifo_cnt < OUT_CNT_W'(OUT_DEPTH)) || pop)
    else $error("median result pushed into full buffer");

  a_push_has_credit: assert property (@(posedge clk) disable iff (rst)
    med_valid |-> (credits > fifo_cnt))
    else $error("median result without a pending credit");

  a_fwd_age: assert property (@(posedge clk) disable iff (rst)
    fwd_valid |-> $past(s1_valid))
    else $error("forwarding beat not from the previous write");
`endif

endmodule

// ===== rtl/core/mf3_median.sv =====
// Three-stage median-of-nine for all channels at once.
// Stage 1 sorts each window row, stage 2 reduces across rows,
// stage 3 takes the median of the three survivors.
module mf3_median import mf3_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_last,
  input  rgb_t taps [WIN_TAPS],
  output logic out_valid,
  output logic out_last,
  output rgb_t med
);

  rgb_t row_lo  [WIN_DIM];
  rgb_t row_mid [WIN_DIM];
  rgb_t row_hi  [WIN_DIM];
  rgb_t row_lo_next  [WIN_DIM];
  rgb_t row_mid_next [WIN_DIM];
  rgb_t row_hi_next  [WIN_DIM];
  logic st1_valid, st1_last;

  rgb_t lo_max, mid_med, hi_min;
  rgb_t lo_max_next, mid_med_next, hi_min_next;
  logic st2_valid, st2_last;

  rgb_t med_next;

  // Stage 1: sort each row of the window
  always_comb begin
    for (int r = 0; r < WIN_DIM; r++) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        row_lo_next[r][c]  = min2(min2(taps[r*WIN_DIM][c], taps[r*WIN_DIM+1][c]),
                                  taps[r*WIN_DIM+2][c]);
        row_hi_next[r][c]  = max2(max2(taps[r*WIN_DIM][c], taps[r*WIN_DIM+1][c]),
                                  taps[r*WIN_DIM+2][c]);
        row_mid_next[r][c] = med3(taps[r*WIN_DIM][c], taps[r*WIN_DIM+1][c],
                                  taps[r*WIN_DIM+2][c]);
      end
    end
  end

  // Stage 2: largest low, median of mids, smallest high
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      lo_max_next[c]  = max2(max2(row_lo[0][c], row_lo[1][c]), row_lo[2][c]);
      mid_med_next[c] = med3(row_mid[0][c], row_mid[1][c], row_mid[2][c]);
      hi_min_next[c]  = min2(min2(row_hi[0][c], row_hi[1][c]), row_hi[2][c]);
    end
  end

  // Stage 3: final median
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      med_next[c] = med3(lo_max[c], mid_med[c], hi_min[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
      st2_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      st1_valid <= in_valid;
      st2_valid <= st1_valid;
      out_valid <= st2_valid;
    end
  end

  always_ff @(posedge clk) begin
    row_lo   <= row_lo_next;
    row_mid  <= row_mid_next;
    row_hi   <= row_hi_next;
    st1_last <= in_last;
    lo_max   <= lo_max_next;
    mid_med  <= mid_med_next;
    hi_min   <= hi_min_next;
    st2_last <= st1_last;
    med      <= med_next;
    out_last <= st2_last;
  end

endmodule
